FILE: rtl/rws_pkg.sv
// Shared constants for the round-trip-time window statistics block.
package rws_pkg;

  localparam int WINDOW  = 32;
  localparam int PTR_W   = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);

  localparam int RTT_W   = 16;
  localparam int ENTRY_W = RTT_W + 1;
  localparam int SUM_W   = RTT_W + CNT_W;
  localparam int TOT_W   = 32;
  localparam int LOSS_W  = 7;
  localparam int HELD_W  = 6;

  localparam int PCT     = 100;
  localparam int DSR_W   = TOT_W;
  localparam int DVD_W   = TOT_W + LOSS_W;
  localparam int STEP_W  = $clog2(DVD_W + 1);

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

endpackage

FILE: rtl/rws_if.sv
// Valid/ready channel interfaces for probe requests and statistics results.
interface rws_req_if
  import rws_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic             probe_ok;
  logic [RTT_W-1:0] rtt_ms;

  modport source (output valid, req_type, probe_ok, rtt_ms, input ready);
  modport sink   (input valid, req_type, probe_ok, rtt_ms, output ready);
endinterface

interface rws_stats_if
  import rws_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              last_valid;
  logic [RTT_W-1:0]  last_rtt;
  logic [RTT_W-1:0]  min_rtt;
  logic [RTT_W-1:0]  avg_rtt;
  logic [RTT_W-1:0]  max_rtt;
  logic [RTT_W-1:0]  jitter_ms;
  logic [LOSS_W-1:0] loss_percent;
  logic [TOT_W-1:0]  sent_total;
  logic [TOT_W-1:0]  lost_total;
  logic [HELD_W-1:0] samples_held;

  modport source (output valid, last_valid, last_rtt, min_rtt, avg_rtt, max_rtt, jitter_ms,
                  loss_percent, sent_total, lost_total, samples_held, input ready);
  modport sink   (input valid, last_valid, last_rtt, min_rtt, avg_rtt, max_rtt, jitter_ms,
                  loss_percent, sent_total, lost_total, samples_held, output ready);
endinterface

FILE: rtl/rtt_window_statistics.sv
// Round-trip-time window statistics: ring memory, walk sequencer and shared serial divider.
//
// Channels: probe (sink) takes one beat per probe result or clear request;
// stats (source) gives one beat of window statistics for every probe beat.
// A record beat writes one entry of a WINDOW-deep ring memory and bumps the
// saturating sent/lost totals; a clear beat empties the ring and the totals.
// After each beat the sequencer reads the held entries one per cycle from the
// ring (registered read) to gather min, max, sum and jitter sums, then
// a single restoring divider, one quotient bit per cycle, works out the mean
// (22 steps), the jitter (22 steps) and the loss percentage (39 steps).
// The next probe beat is taken only once the stats beat is formed, so the
// block works on one probe beat at a time, first the ring read walk and
// then the divider.
// probe.ready is high only while the sequencer waits for work. A finished
// result sits in the stats output register while the next probe is worked
// on; if the receiver still stalls when the next result is done, the
// sequencer holds it until the register frees.
// Reset (rst, synchronous) empties the window and the totals; no ring sweep.
module rtt_window_statistics
  import rws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rws_req_if.sink     probe,
  rws_stats_if.source stats
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [1:0] DIV_AVG  = 2'd0;
  localparam logic [1:0] DIV_JIT  = 2'd1;
  localparam logic [1:0] DIV_LOSS = 2'd2;

  logic [2:0] state;

  // ring memory
  logic [ENTRY_W-1:0] ring [WINDOW];
  logic [ENTRY_W-1:0] ring_q;
  logic               ring_we;
  logic               ring_re;
  logic [ENTRY_W-1:0] ring_wdata;

  logic [PTR_W-1:0] wp;
  logic [CNT_W-1:0] held;
  logic [TOT_W-1:0] sent;
  logic [TOT_W-1:0] lost;

  // walk
  logic [PTR_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_left;
  logic             rd_valid;
  logic             rd_last;

  // accumulators
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] jsum;
  logic [CNT_W-1:0] nvalid;
  logic [CNT_W-1:0] jn;
  logic [RTT_W-1:0] mn;
  logic [RTT_W-1:0] mx;
  logic [RTT_W-1:0] prev;
  logic             prev_ok;
  logic             last_ok;
  logic [RTT_W-1:0] last_t;

  // divider
  logic [1:0]        div_sel;
  logic [DVD_W-1:0]  dvd;
  logic [DSR_W-1:0]  dsr;
  logic [DSR_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic [RTT_W-1:0]  avg_q;
  logic [RTT_W-1:0]  jit_q;
  logic [LOSS_W-1:0] loss_q;

  // output register
  logic out_valid;
  logic out_load;

  logic             accept;
  logic [CNT_W:0]   start_wide;
  logic [RTT_W-1:0] q_t;
  logic             q_ok;
  logic [RTT_W-1:0] diff;
  logic [PTR_W-1:0] rd_idx_inc;
  logic [PTR_W-1:0] wp_inc;
  logic [DVD_W-1:0] lost_x100;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_sub;
  logic             fits;
  logic [DVD_W-1:0] dvd_new;
  logic [DSR_W-1:0] rem_new;
  logic [DVD_W-1:0] load_dvd;
  logic [DSR_W-1:0] load_dsr;
  logic [STEP_W-1:0] load_steps;

  assign accept      = probe.valid && probe.ready;
  assign probe.ready = !rst && (state == S_IDLE);

  assign ring_we    = accept && (probe.req_type == REQ_RECORD);
  assign ring_wdata = probe.probe_ok ? {1'b1, probe.rtt_ms} : '0;
  assign ring_re    = (state == S_WALK) && (rd_left != '0);

  assign out_load = (state == S_DONE) && (!out_valid || stats.ready);

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wp] <= ring_wdata;
    end
    if (ring_re) begin
      ring_q <= ring[rd_idx];
    end
  end

  assign wp_inc     = (wp == PTR_W'(WINDOW - 1)) ? '0 : wp + 1'b1;
  assign rd_idx_inc = (rd_idx == PTR_W'(WINDOW - 1)) ? '0 : rd_idx + 1'b1;

  // oldest held entry sits held slots behind the write pointer
  assign start_wide = (CNT_W + 1)'(wp) - (CNT_W + 1)'(held)
                    + (((CNT_W + 1)'(wp) >= (CNT_W + 1)'(held)) ? '0 : (CNT_W + 1)'(WINDOW));

  assign q_ok = ring_q[RTT_W];
  assign q_t  = ring_q[RTT_W-1:0];
  assign diff = (q_t > prev) ? q_t - prev : prev - q_t;

  // lost * 100 as shifted adds
  assign lost_x100 = (DVD_W'(lost) << 6) + (DVD_W'(lost) << 5) + (DVD_W'(lost) << 2);

  always_comb begin
    unique case (div_sel)
      DIV_AVG: begin
        load_dvd   = DVD_W'(sum) << (DVD_W - SUM_W);
        load_dsr   = DSR_W'(nvalid);
        load_steps = STEP_W'(SUM_W);
      end
      DIV_JIT: begin
        load_dvd   = DVD_W'(jsum) << (DVD_W - SUM_W);
        load_dsr   = DSR_W'(jn);
        load_steps = STEP_W'(SUM_W);
      end
      default: begin
        load_dvd   = lost_x100;
        load_dsr   = sent;
        load_steps = STEP_W'(DVD_W);
      end
    endcase
  end

  // one restoring step
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign fits    = (rem_sh >= {1'b0, dsr});
  assign rem_new = fits ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
  assign dvd_new = {dvd[DVD_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      held      <= '0;
      sent      <= '0;
      lost      <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      div_sel   <= DIV_AVG;
    end else begin
      rd_valid <= ring_re;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (stats.valid && stats.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (probe.req_type == REQ_CLEAR) begin
              wp   <= '0;
              held <= '0;
              sent <= '0;
              lost <= '0;
            end else begin
              wp <= wp_inc;
              if (held != CNT_W'(WINDOW)) begin
                held <= held + 1'b1;
              end
              if (sent != '1) begin
                sent <= sent + 1'b1;
                if (!probe.probe_ok) begin
                  lost <= lost + 1'b1;
                end
              end
            end
            sum     <= '0;
            jsum    <= '0;
            nvalid  <= '0;
            jn      <= '0;
            mn      <= '1;
            mx      <= '0;
            prev    <= '0;
            prev_ok <= 1'b0;
            last_ok <= 1'b0;
            last_t  <= '0;
            state   <= S_START;
          end
        end
        S_START: begin
          rd_idx  <= start_wide[PTR_W-1:0];
          rd_left <= held;
          div_sel <= DIV_AVG;
          state   <= (held == '0) ? S_LOAD : S_WALK;
        end
        S_WALK: begin
          if (ring_re) begin
            rd_idx   <= rd_idx_inc;
            rd_left  <= rd_left - 1'b1;
            rd_last  <= (rd_left == CNT_W'(1));
          end
          if (rd_valid) begin
            if (q_ok) begin
              sum    <= sum + SUM_W'(q_t);
              nvalid <= nvalid + 1'b1;
              if (q_t < mn) begin
                mn <= q_t;
              end
              if (q_t > mx) begin
                mx <= q_t;
              end
              if (prev_ok) begin
                jsum <= jsum + SUM_W'(diff);
                jn   <= jn + 1'b1;
              end
              prev <= q_t;
            end
            prev_ok <= q_ok;
            if (rd_last) begin
              last_ok <= q_ok;
              last_t  <= q_ok ? q_t : '0;
              state   <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          dvd   <= load_dvd;
          dsr   <= load_dsr;
          rem   <= '0;
          steps <= load_steps;
          if (load_dsr == '0) begin
            // nothing to divide by: the figure is zero
            unique case (div_sel)
              DIV_AVG: avg_q  <= '0;
              DIV_JIT: jit_q  <= '0;
              default: loss_q <= '0;
            endcase
            if (div_sel == DIV_LOSS) begin
              state <= S_DONE;
            end else begin
              div_sel <= div_sel + 1'b1;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dvd   <= dvd_new;
          rem   <= rem_new;
          steps <= steps - 1'b1;
          if (steps == STEP_W'(1)) begin
            unique case (div_sel)
              DIV_AVG: avg_q  <= dvd_new[RTT_W-1:0];
              DIV_JIT: jit_q  <= dvd_new[RTT_W-1:0];
              default: loss_q <= dvd_new[LOSS_W-1:0];
            endcase
            if (div_sel == DIV_LOSS) begin
              state <= S_DONE;
            end else begin
              div_sel <= div_sel + 1'b1;
              state   <= S_LOAD;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            stats.last_valid   <= last_ok;
            stats.last_rtt     <= last_t;
            stats.min_rtt      <= (nvalid == '0) ? '0 : mn;
            stats.avg_rtt      <= avg_q;
            stats.max_rtt      <= mx;
            stats.jitter_ms    <= jit_q;
            stats.loss_percent <= loss_q;
            stats.sent_total   <= sent;
            stats.lost_total   <= lost;
            stats.samples_held <= HELD_W'(held);
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stats.valid = out_valid;

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(WINDOW))
    else $error("held count beyond window");

  a_lost_le_sent: assert property (@(posedge clk) disable iff (rst)
    lost <= sent)
    else $error("lost total above sent total");

  a_loss_range: assert property (@(posedge clk) disable iff (rst)
    stats.valid |-> stats.loss_percent <= LOSS_W'(PCT))
    else $error("loss percentage above 100");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && probe.req_type == REQ_CLEAR |=> held == '0 && sent == '0 && lost == '0)
    else $error("clear did not empty statistics");

  a_read_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> state == S_WALK)
    else $error("ring read data outside walk");

endmodule
